/* design/mpbm_pkg.sv */
package mpbm_pkg;

  localparam int NodeCountDef   = 1024;
  localparam int SymbolCountDef = 256;

  typedef enum logic [1:0] {
    CMD_SCAN = 2'd0,
    CMD_GOTO = 2'd1,
    CMD_NODE = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [1:0] command;
    logic [9:0] node_index;
    logic [7:0] edge_symbol;
    logic [9:0] edge_target;
    logic       edge_present;
    logic [9:0] failure_target;
    logic       accepting;
    logic [7:0] scan_byte;
    logic       last_byte;
  } mpbm_in_t;

  typedef struct packed {
    logic [9:0] current_node;
    logic       hit;
    logic       any_hit;
    logic       text_end;
  } mpbm_out_t;

  typedef struct packed {
    logic       present;
    logic [9:0] target;
  } goto_ent_t;

  typedef struct packed {
    logic       accept;
    logic [9:0] fail;
  } node_ent_t;

  // Table port control: one shared address per memory, write or read.
  typedef struct packed {
    logic      goto_we;
    logic      node_we;
    logic      rd_en;
    goto_ent_t goto_wdata;
    node_ent_t node_wdata;
  } tbl_req_t;

endpackage

/* design/mpbm_tables.sv */
module mpbm_tables #(
  parameter int NODE_COUNT   = mpbm_pkg::NodeCountDef,
  parameter int SYMBOL_COUNT = mpbm_pkg::SymbolCountDef,
  localparam int NODE_W = $clog2(NODE_COUNT),
  localparam int SYM_W  = $clog2(SYMBOL_COUNT)
) (
  input  logic                clk_i,
  input  mpbm_pkg::tbl_req_t  req_i,
  input  logic [NODE_W-1:0]   node_i,
  input  logic [SYM_W-1:0]    sym_i,
  output mpbm_pkg::goto_ent_t goto_rd_o,
  output mpbm_pkg::node_ent_t node_rd_o
);
  import mpbm_pkg::*;

  localparam int NodeDepth = 1 << NODE_W;
  localparam int GotoDepth = 1 << (NODE_W + SYM_W);

  goto_ent_t goto_mem [GotoDepth];
  node_ent_t node_mem [NodeDepth];
  goto_ent_t goto_rd_q;
  node_ent_t node_rd_q;

  // Dense goto table: row per node, column per symbol.
  always_ff @(posedge clk_i) begin
    if (req_i.goto_we) begin
      goto_mem[{node_i, sym_i}] <= req_i.goto_wdata;
    end
    if (req_i.rd_en) begin
      goto_rd_q <= goto_mem[{node_i, sym_i}];
    end
  end

  // Failure link and accept flag per node.
  always_ff @(posedge clk_i) begin
    if (req_i.node_we) begin
      node_mem[node_i] <= req_i.node_wdata;
    end
    if (req_i.rd_en) begin
      node_rd_q <= node_mem[node_i];
    end
  end

  assign goto_rd_o = goto_rd_q;
  assign node_rd_o = node_rd_q;

endmodule

/* design/mpbm_ctrl.sv */
module mpbm_ctrl #(
  parameter int NODE_COUNT   = mpbm_pkg::NodeCountDef,
  parameter int SYMBOL_COUNT = mpbm_pkg::SymbolCountDef,
  localparam int NODE_W = $clog2(NODE_COUNT),
  localparam int SYM_W  = $clog2(SYMBOL_COUNT)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mpbm_pkg::mpbm_in_t  in_data_i,
  output logic                res_valid_o,
  output mpbm_pkg::mpbm_out_t res_o,
  input  logic                res_free_i,
  output mpbm_pkg::tbl_req_t  tbl_o,
  output logic [NODE_W-1:0]   tbl_node_o,
  output logic [SYM_W-1:0]    tbl_sym_o,
  input  mpbm_pkg::goto_ent_t goto_rd_i,
  input  mpbm_pkg::node_ent_t node_rd_i
);
  import mpbm_pkg::*;

  localparam int STEP_W = $clog2(NODE_COUNT + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_LOOK = 3'b010,
    S_ACC  = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [9:0]        scan_node_q, scan_node_d;
  logic              seen_q, seen_d;
  logic [9:0]        node_q, node_d;
  logic              node_ok_q, node_ok_d;
  logic [STEP_W-1:0] steps_q, steps_d;
  logic [7:0]        byte_q, byte_d;
  logic              last_q, last_d;

  logic              acc_in;
  logic              sym_ok;
  logic              edge_hit;
  logic [9:0]        fail_node;
  logic [9:0]        res_node;
  logic              res_hit;

  function automatic logic [NODE_W-1:0] node_idx(input logic [9:0] n);
    logic [31:0] w;
    w = 32'(n);
    return w[NODE_W-1:0];
  endfunction

  function automatic logic [SYM_W-1:0] sym_idx(input logic [7:0] s);
    logic [31:0] w;
    w = 32'(s);
    return w[SYM_W-1:0];
  endfunction

  function automatic logic node_in_range(input logic [9:0] n);
    return 32'(n) < NODE_COUNT;
  endfunction

  function automatic logic sym_in_range(input logic [7:0] s);
    return 32'(s) < SYMBOL_COUNT;
  endfunction

  assign in_stall_o = (state_q != S_IDLE);
  assign acc_in     = in_valid_i && !in_stall_o;
  assign sym_ok     = sym_in_range(byte_q);
  assign edge_hit   = node_ok_q && sym_ok && goto_rd_i.present;
  // Out-of-range nodes read as all-zero entries.
  assign fail_node  = node_ok_q ? node_rd_i.fail : 10'd0;

  always_comb begin
    state_d     = state_q;
    scan_node_d = scan_node_q;
    seen_d      = seen_q;
    node_d      = node_q;
    node_ok_d   = node_ok_q;
    steps_d     = steps_q;
    byte_d      = byte_q;
    last_d      = last_q;
    tbl_o       = '0;
    tbl_node_o  = node_idx(node_q);
    tbl_sym_o   = sym_idx(byte_q);
    res_valid_o = 1'b0;
    res_node    = node_q;
    res_hit     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (acc_in) begin
          unique case (cmd_e'(in_data_i.command))
            CMD_GOTO: begin
              tbl_o.goto_we = node_in_range(in_data_i.node_index) &&
                              sym_in_range(in_data_i.edge_symbol);
              tbl_o.goto_wdata.present = in_data_i.edge_present;
              tbl_o.goto_wdata.target  = in_data_i.edge_present ?
                                         in_data_i.edge_target : 10'd0;
              tbl_node_o = node_idx(in_data_i.node_index);
              tbl_sym_o  = sym_idx(in_data_i.edge_symbol);
            end
            CMD_NODE: begin
              tbl_o.node_we = node_in_range(in_data_i.node_index);
              tbl_o.node_wdata.accept = in_data_i.accepting;
              tbl_o.node_wdata.fail   = in_data_i.failure_target;
              tbl_node_o = node_idx(in_data_i.node_index);
            end
            CMD_SCAN: begin
              tbl_o.rd_en = 1'b1;
              tbl_node_o  = node_idx(scan_node_q);
              tbl_sym_o   = sym_idx(in_data_i.scan_byte);
              node_d      = scan_node_q;
              node_ok_d   = node_in_range(scan_node_q);
              steps_d     = '0;
              byte_d      = in_data_i.scan_byte;
              last_d      = in_data_i.last_byte;
              state_d     = S_LOOK;
            end
            default: ;
          endcase
        end
      end
      S_LOOK: begin
        if (edge_hit) begin
          // Move along the edge, then fetch the accept flag of the target.
          node_d      = goto_rd_i.target;
          node_ok_d   = node_in_range(goto_rd_i.target);
          tbl_o.rd_en = 1'b1;
          tbl_node_o  = node_idx(goto_rd_i.target);
          state_d     = S_ACC;
        end else if (node_q == 10'd0 || steps_q >= STEP_W'(NODE_COUNT)) begin
          // Root without edge, or a cyclic failure chain: land at root.
          res_valid_o = 1'b1;
          res_node    = 10'd0;
        end else begin
          node_d      = fail_node;
          node_ok_d   = node_in_range(fail_node);
          steps_d     = steps_q + STEP_W'(1);
          tbl_o.rd_en = 1'b1;
          tbl_node_o  = node_idx(fail_node);
        end
      end
      S_ACC: begin
        res_valid_o = 1'b1;
        res_hit     = (node_q != 10'd0) && node_ok_q && node_rd_i.accept;
      end
      default: state_d = S_IDLE;
    endcase

    if (res_valid_o && res_free_i) begin
      scan_node_d = last_q ? 10'd0 : res_node;
      seen_d      = last_q ? 1'b0 : (seen_q || res_hit);
      state_d     = S_IDLE;
    end
  end

  assign res_o.current_node = res_node;
  assign res_o.hit          = res_hit;
  assign res_o.any_hit      = seen_q || res_hit;
  assign res_o.text_end     = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      scan_node_q <= 10'd0;
      seen_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_node_q <= scan_node_d;
      seen_q      <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q    <= node_d;
    node_ok_q <= node_ok_d;
    steps_q   <= steps_d;
    byte_q    <= byte_d;
    last_q    <= last_d;
  end

  a_scan_starts_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_in && in_data_i.command == CMD_SCAN) |=> state_q == S_LOOK)
    else $error("scan transfer did not start a table lookup");

  a_write_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tbl_o.goto_we || tbl_o.node_we) |-> state_q == S_IDLE)
    else $error("table write outside idle");

  a_steps_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LOOK |-> steps_q <= STEP_W'(NODE_COUNT))
    else $error("failure step count past node count");

  a_text_end_to_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_free_i && last_q) |=> (scan_node_q == 10'd0 && !seen_q))
    else $error("scan state not back at root after last byte");

  a_result_not_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> state_q != S_IDLE)
    else $error("result raised while idle");

endmodule

/* design/multi_pattern_byte_matcher_unit.sv */
// Scan command: the transfer reads the current node; a taken edge adds a read of
// the target's accept flag, a scan that stays at the root gives its result from
// the first read, and each failure link followed adds a read of the single-port
// goto and node memories. Write commands give no result. One item is in work at
// a time; a waiting result sits in the output register. Reset returns the scan
// to the root and clears the hit flag; table contents are undefined until written.
module multi_pattern_byte_matcher_unit #(
  parameter int NODE_COUNT   = mpbm_pkg::NodeCountDef,
  parameter int SYMBOL_COUNT = mpbm_pkg::SymbolCountDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mpbm_pkg::mpbm_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mpbm_pkg::mpbm_out_t out_data_o
);
  import mpbm_pkg::*;

  localparam int NODE_W = $clog2(NODE_COUNT);
  localparam int SYM_W  = $clog2(SYMBOL_COUNT);

  tbl_req_t          tbl_req;
  logic [NODE_W-1:0] tbl_node;
  logic [SYM_W-1:0]  tbl_sym;
  goto_ent_t         goto_rd;
  node_ent_t         node_rd;
  logic              res_valid;
  mpbm_out_t         res;
  logic              res_free;

  logic              out_valid_q, out_valid_d;
  mpbm_out_t         out_q;

  mpbm_ctrl #(
    .NODE_COUNT  (NODE_COUNT),
    .SYMBOL_COUNT(SYMBOL_COUNT)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .res_valid_o(res_valid),
    .res_o      (res),
    .res_free_i (res_free),
    .tbl_o      (tbl_req),
    .tbl_node_o (tbl_node),
    .tbl_sym_o  (tbl_sym),
    .goto_rd_i  (goto_rd),
    .node_rd_i  (node_rd)
  );

  mpbm_tables #(
    .NODE_COUNT  (NODE_COUNT),
    .SYMBOL_COUNT(SYMBOL_COUNT)
  ) u_tables (
    .clk_i    (clk_i),
    .req_i    (tbl_req),
    .node_i   (tbl_node),
    .sym_i    (tbl_sym),
    .goto_rd_o(goto_rd),
    .node_rd_o(node_rd)
  );

  // Output slot is free when empty or when its transfer completes this cycle.
  assign res_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_free) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_free) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
